/* sv/rfhp_pkg.sv */
// rfhp_pkg: types, constants and decode functions for range_frame_to_haptic_pulse.
// No dependencies; every other file imports it.
package rfhp_pkg;

  localparam int BYTE_W     = 8;
  localparam int RANGE_W    = 10;
  localparam int TIMER_W    = 8;
  localparam int DIGIT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [BYTE_W-1:0]  START_BYTE  = 8'h52;
  localparam logic [BYTE_W-1:0]  CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0]  CHAR_EIGHT  = 8'h38;
  localparam logic [DIGIT_W-1:0] DIGIT_OTHER = 4'd9;

  localparam logic [RANGE_W-1:0] LOWER_RESET = 10'd40;
  localparam logic [RANGE_W-1:0] UPPER_RESET = 10'd80;

  localparam logic [RANGE_W-1:0] BAND_50 = 10'd50;
  localparam logic [RANGE_W-1:0] BAND_60 = 10'd60;
  localparam logic [RANGE_W-1:0] BAND_70 = 10'd70;
  localparam logic [RANGE_W-1:0] BAND_80 = 10'd80;

  localparam logic [TIMER_W-1:0] ON_SHORT  = 8'd150;
  localparam logic [TIMER_W-1:0] ON_LONG   = 8'd180;
  localparam logic [TIMER_W-1:0] OFF_70    = 8'd230;
  localparam logic [TIMER_W-1:0] OFF_60    = 8'd150;
  localparam logic [TIMER_W-1:0] OFF_50    = 8'd125;
  localparam logic [TIMER_W-1:0] OFF_OTHER = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER = 1'b0,
    CFG_UPPER = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } pulse_ph_t;

  typedef enum logic [3:0] {
    FR_WAIT = 4'b0001,
    FR_HUND = 4'b0010,
    FR_TENS = 4'b0100,
    FR_ONES = 4'b1000
  } frame_ph_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic               is_tick;
    logic               is_start;
    logic [DIGIT_W-1:0] digit;
    logic [BYTE_W-1:0]  rx_byte;
  } item_cls_t;

  typedef struct packed {
    logic [TIMER_W-1:0] on_t;
    logic [TIMER_W-1:0] off_t;
  } pulse_times_t;

  typedef struct packed {
    logic               echo_valid;
    logic [BYTE_W-1:0]  echo_byte;
    logic               motor_on;
    logic               range_valid;
    logic [RANGE_W-1:0] range_value;
    logic               byte_dropped;
  } result_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    d = b - CHAR_ZERO;
    if (b >= CHAR_ZERO && b <= CHAR_EIGHT) return d[DIGIT_W-1:0];
    return DIGIT_OTHER;
  endfunction

  function automatic pulse_times_t band_times(input logic [RANGE_W-1:0] r);
    pulse_times_t t;
    if (r >= BAND_70 && r < BAND_80) begin
      t.on_t = ON_SHORT; t.off_t = OFF_70;
    end else if (r >= BAND_60 && r < BAND_70) begin
      t.on_t = ON_LONG;  t.off_t = OFF_60;
    end else if (r >= BAND_50 && r < BAND_60) begin
      t.on_t = ON_LONG;  t.off_t = OFF_50;
    end else begin
      t.on_t = ON_SHORT; t.off_t = OFF_OTHER;
    end
    return t;
  endfunction

endpackage

/* sv/rfhp_if.sv */
// rfhp_if: valid/ready channel interfaces for the input items and result items.
// Depends on rfhp_pkg.
interface rfhp_in_if import rfhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface rfhp_out_if import rfhp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               echo_valid;
  logic [BYTE_W-1:0]  echo_byte;
  logic               motor_on;
  logic               range_valid;
  logic [RANGE_W-1:0] range_value;
  logic               byte_dropped;

  modport source (output valid, echo_valid, echo_byte, motor_on, range_valid, range_value,
                  byte_dropped, input ready);
  modport sink   (input valid, echo_valid, echo_byte, motor_on, range_valid, range_value,
                  byte_dropped, output ready);
endinterface

/* sv/rfhp_front.sv */
// rfhp_front: accepts input items and classifies them (tick, start byte, digit value).
// Depends on rfhp_pkg and rfhp_in_if.
module rfhp_front import rfhp_pkg::*; (
  rfhp_in_if.sink   in_ch,
  input  logic      q_full,
  output logic      push,
  output item_cls_t push_data
);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_data.is_tick  = in_ch.kind;
    push_data.is_start = (in_ch.rx_byte == START_BYTE);
    push_data.digit    = digit_of(in_ch.rx_byte);
    push_data.rx_byte  = in_ch.rx_byte;
  end

endmodule

/* sv/rfhp_queue.sv */
// rfhp_queue: two-entry FIFO of classified items between front and back.
// Depends on rfhp_pkg.
module rfhp_queue import rfhp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_cls_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output item_cls_t pop_data
);

  item_cls_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r[1];
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/rfhp_back.sv */
// rfhp_back: frame decoder, pulse sequencer and registered result stage.
// Depends on rfhp_pkg and rfhp_out_if.
module rfhp_back import rfhp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_cls_t          q_data,
  output logic               pop,
  input  logic [RANGE_W-1:0] lower_limit,
  input  logic [RANGE_W-1:0] upper_limit,
  rfhp_out_if.source         out_ch
);

  frame_ph_t          frame_r, frame_nxt;
  logic [RANGE_W-1:0] part_r, part_nxt;
  pulse_ph_t          pulse_r, pulse_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [TIMER_W-1:0] off_r, off_nxt;
  logic               ovalid_r;
  result_t            res_r, res_nxt;

  logic [RANGE_W+3:0] acc;
  logic [RANGE_W-1:0] range_new;
  logic [TIMER_W-1:0] timer_dec;
  logic               busy;
  pulse_times_t       times;

  assign pop = q_valid && (!ovalid_r || out_ch.ready);

  always_comb begin
    acc       = {1'b0, part_r, 3'b000} + {3'b000, part_r, 1'b0} + {10'd0, q_data.digit};
    range_new = acc[RANGE_W-1:0];
    times     = band_times(range_new);
    timer_dec = (timer_r != '0) ? timer_r - 1'b1 : timer_r;
    busy      = (pulse_r == PH_ON) || (pulse_r == PH_OFF);

    frame_nxt = frame_r;
    part_nxt  = part_r;
    pulse_nxt = pulse_r;
    timer_nxt = timer_r;
    off_nxt   = off_r;
    res_nxt   = '0;

    if (q_data.is_tick) begin
      unique case (pulse_r)
        PH_ON: begin
          timer_nxt = timer_dec;
          if (timer_dec == '0) begin
            pulse_nxt = PH_OFF;
            timer_nxt = off_r;
          end
        end
        PH_OFF: begin
          timer_nxt = timer_dec;
          if (timer_dec == '0) pulse_nxt = PH_IDLE;
        end
        default: pulse_nxt = PH_IDLE;
      endcase
    end else if (busy) begin
      res_nxt.byte_dropped = 1'b1;
    end else begin
      res_nxt.echo_valid = 1'b1;
      res_nxt.echo_byte  = q_data.rx_byte;
      unique case (frame_r)
        FR_WAIT: begin
          if (q_data.is_start) begin
            frame_nxt = FR_HUND;
            part_nxt  = '0;
          end
        end
        FR_HUND: begin
          part_nxt  = range_new;
          frame_nxt = FR_TENS;
        end
        FR_TENS: begin
          part_nxt  = range_new;
          frame_nxt = FR_ONES;
        end
        FR_ONES: begin
          part_nxt            = range_new;
          frame_nxt           = FR_WAIT;
          res_nxt.range_valid = 1'b1;
          res_nxt.range_value = range_new;
          if (range_new >= lower_limit && range_new <= upper_limit) begin
            pulse_nxt = PH_ON;
            timer_nxt = times.on_t;
            off_nxt   = times.off_t;
          end
        end
        default: frame_nxt = FR_WAIT;
      endcase
    end
    res_nxt.motor_on = (pulse_nxt == PH_ON);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= FR_WAIT;
      part_r   <= '0;
      pulse_r  <= PH_IDLE;
      timer_r  <= '0;
      off_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (pop) begin
        frame_r <= frame_nxt;
        part_r  <= part_nxt;
        pulse_r <= pulse_nxt;
        timer_r <= timer_nxt;
        off_r   <= off_nxt;
      end
      if (pop) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.echo_valid   = res_r.echo_valid;
  assign out_ch.echo_byte    = res_r.echo_byte;
  assign out_ch.motor_on     = res_r.motor_on;
  assign out_ch.range_valid  = res_r.range_valid;
  assign out_ch.range_value  = res_r.range_value;
  assign out_ch.byte_dropped = res_r.byte_dropped;

endmodule

/* sv/range_frame_to_haptic_pulse.sv */
// range_frame_to_haptic_pulse: top level with limit registers, front, queue and back.
// Depends on rfhp_pkg, rfhp_if, rfhp_front, rfhp_queue, rfhp_back.
//
// Takes one item per clock (a serial byte or a millisecond tick) while the queue has
// room, and returns exactly one result item per input item, in order. Sustained rate
// is one item per cycle when the output is not stalled; a result is registered in the
// queue and then in the result stage. The back end sets the rate, updating frame and
// pulse state for one item each cycle that it pops; the two-entry queue lets input
// and output stall independently. The user must write limits through cfg_we/cfg_idx/
// cfg_wdata only while the block is idle; the block itself does not enforce this.
module range_frame_to_haptic_pulse import rfhp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rfhp_in_if.sink               in_ch,
  rfhp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [RANGE_W-1:0] lower_r, upper_r;
  logic               q_full, q_push, q_pop, q_valid;
  item_cls_t          q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_LOWER: lower_r <= cfg_wdata[RANGE_W-1:0];
        CFG_UPPER: upper_r <= cfg_wdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  rfhp_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_wdata)
  );

  rfhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  rfhp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_rdata),
    .pop         (q_pop),
    .lower_limit (lower_r),
    .upper_limit (upper_r),
    .out_ch      (out_ch)
  );

endmodule

/* sv/rfhp_checker.sv */
// rfhp_props: port-level assertions on the result channel, bound to the top level.
// Depends on rfhp_pkg and range_frame_to_haptic_pulse.
module rfhp_props import rfhp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               echo_valid,
  input logic [BYTE_W-1:0]  echo_byte,
  input logic               range_valid,
  input logic [RANGE_W-1:0] range_value,
  input logic               byte_dropped
);

  localparam logic [RANGE_W-1:0] RANGE_MAX = 10'd999;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(echo_byte) && $stable(range_value))
    else $error("result changed while stalled");

  a_range_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && range_valid |-> echo_valid && range_value <= RANGE_MAX)
    else $error("range reported without echo or out of bounds");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_dropped |-> !echo_valid && !range_valid)
    else $error("dropped byte echoed or decoded");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (echo_valid || echo_byte == '0) && (range_valid || range_value == '0))
    else $error("payload not cleared");

endmodule

bind range_frame_to_haptic_pulse rfhp_props u_rfhp_props (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .echo_valid   (out_ch.echo_valid),
  .echo_byte    (out_ch.echo_byte),
  .range_valid  (out_ch.range_valid),
  .range_value  (out_ch.range_value),
  .byte_dropped (out_ch.byte_dropped)
);

/* sim/rfhp_checker.sv */
// rfhp_checker: watches the item and result channels and the limit write port,
// predicts every result item and compares it field by field with what comes out.
// Depends on rfhp_pkg and rfhp_if.
module rfhp_checker import rfhp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rfhp_in_if                    in_ch,
  rfhp_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    errors,
  output logic                  pulse_busy
);

  logic [RANGE_W-1:0] lim_lo, lim_hi;
  frame_ph_t          fr;
  logic [RANGE_W-1:0] acc;
  pulse_ph_t          ph;
  logic [TIMER_W-1:0] tmr;
  logic [TIMER_W-1:0] off_len;
  result_t            pending_results[$];

  function automatic result_t haptic_result(input logic is_tick, input logic [BYTE_W-1:0] b);
    result_t          r;
    logic [DIGIT_W-1:0] d;
    r = '0;
    if (is_tick) begin
      if (ph == PH_ON || ph == PH_OFF) begin
        if (tmr != '0) tmr = tmr - 1'b1;
        if (tmr == '0) begin
          if (ph == PH_ON) begin
            ph  = PH_OFF;
            tmr = off_len;
          end else begin
            ph = PH_IDLE;
          end
        end
      end else begin
        ph = PH_IDLE;
      end
    end else if (ph == PH_ON || ph == PH_OFF) begin
      r.byte_dropped = 1'b1;
    end else begin
      r.echo_valid = 1'b1;
      r.echo_byte  = b;
      if (fr == FR_WAIT) begin
        if (b == START_BYTE) begin
          fr  = FR_HUND;
          acc = '0;
        end
      end else begin
        d   = (b >= CHAR_ZERO && b <= CHAR_EIGHT) ? b[DIGIT_W-1:0] : DIGIT_OTHER;
        acc = RANGE_W'(acc * 10 + d);
        if (fr == FR_ONES) begin
          fr            = FR_WAIT;
          r.range_valid = 1'b1;
          r.range_value = acc;
          if (acc >= lim_lo && acc <= lim_hi) begin
            ph = PH_ON;
            if (acc >= BAND_70 && acc < BAND_80) begin
              tmr = ON_SHORT; off_len = OFF_70;
            end else if (acc >= BAND_60 && acc < BAND_70) begin
              tmr = ON_LONG;  off_len = OFF_60;
            end else if (acc >= BAND_50 && acc < BAND_60) begin
              tmr = ON_LONG;  off_len = OFF_50;
            end else begin
              tmr = ON_SHORT; off_len = OFF_OTHER;
            end
          end
        end else if (fr == FR_HUND) begin
          fr = FR_TENS;
        end else begin
          fr = FR_ONES;
        end
      end
    end
    r.motor_on = (ph == PH_ON);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      lim_lo  = LOWER_RESET;
      lim_hi  = UPPER_RESET;
      fr      = FR_WAIT;
      acc     = '0;
      ph      = PH_IDLE;
      tmr     = '0;
      off_len = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_LOWER) lim_lo = cfg_wdata;
        else lim_hi = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.echo_valid   = out_ch.echo_valid;
        seen.echo_byte    = out_ch.echo_byte;
        seen.motor_on     = out_ch.motor_on;
        seen.range_valid  = out_ch.range_valid;
        seen.range_value  = out_ch.range_value;
        seen.byte_dropped = out_ch.byte_dropped;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result item expected none got %p", $time, seen);
        end else begin
          want = pending_results.pop_front();
          check_field("echo_valid", 32'(want.echo_valid), 32'(seen.echo_valid));
          check_field("echo_byte", 32'(want.echo_byte), 32'(seen.echo_byte));
          check_field("motor_on", 32'(want.motor_on), 32'(seen.motor_on));
          check_field("range_valid", 32'(want.range_valid), 32'(seen.range_valid));
          check_field("range_value", 32'(want.range_value), 32'(seen.range_value));
          check_field("byte_dropped", 32'(want.byte_dropped), 32'(seen.byte_dropped));
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(haptic_result(in_ch.kind, in_ch.rx_byte));
    end
    pending    <= pending_results.size();
    pulse_busy <= (ph != PH_IDLE);
  end

endmodule

/* sim/testbench.sv */
// testbench: drives serial bytes, ticks and limit writes into range_frame_to_haptic_pulse
// with random gaps and output stalls; rfhp_checker does the prediction and comparison.
// Depends on rfhp_pkg, rfhp_if, range_frame_to_haptic_pulse and rfhp_checker.
module testbench;
  import rfhp_pkg::*;

  localparam int PHASE_ITEMS    = 240;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    pending;
  int                    errors;
  logic                  pulse_busy;
  bit                    calm;
  int                    stall_left = 0;
  int                    quiet_cycles = 0;
  int                    live_items = 0;

  rfhp_in_if  in_ch();
  rfhp_out_if out_ch();

  range_frame_to_haptic_pulse uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  rfhp_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .errors     (errors),
    .pulse_busy (pulse_busy)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_item(input logic is_tick, input logic [BYTE_W-1:0] b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= is_tick;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (is_tick || !pulse_busy) live_items++;
  endtask

  task automatic send_tick();
    send_item(1'b1, BYTE_W'($urandom_range(0, 255)));
  endtask

  function automatic logic [BYTE_W-1:0] digit_byte(input int d);
    logic [BYTE_W-1:0] b;
    if (d < 9) return CHAR_ZERO + BYTE_W'(d);
    b = BYTE_W'($urandom_range(0, 255));
    if (b >= CHAR_ZERO && b <= CHAR_EIGHT) b = b + 8'h40;
    return b;
  endfunction

  task automatic send_frame(input int target);
    int d;
    send_item(1'b0, START_BYTE);
    for (int i = 0; i < 3; i++) begin
      d = (i == 0) ? target / 100 : (i == 1) ? (target / 10) % 10 : target % 10;
      if ($urandom_range(0, 5) == 0) send_tick();
      send_item(1'b0, digit_byte(d));
    end
  endtask

  function automatic int pick_target(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return ($urandom_range(0, 1) == 0) ? lo : hi;
    if (r < 55 && lo <= hi) return $urandom_range(lo, hi);
    if (r < 80) return $urandom_range(35, 85);
    return $urandom_range(0, 999);
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic run_phase(input int lo, input int hi, input bit do_write);
    int goal;
    int r;
    if (do_write) begin
      drain();
      write_limit(CFG_LOWER, lo);
      write_limit(CFG_UPPER, hi);
      cfg_we <= 1'b0;
    end
    goal = live_items + PHASE_ITEMS;
    while (live_items < goal) begin
      if ($urandom_range(0, 14) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (pulse_busy) begin
        if (r < 90) repeat ($urandom_range(1, 40)) send_tick();
        else send_item(1'b0, BYTE_W'($urandom_range(0, 255)));
      end else if (r < 55) begin
        send_frame(pick_target(lo, hi));
      end else if (r < 75) begin
        repeat ($urandom_range(1, 6)) send_tick();
      end else if (r < 85) begin
        send_item(1'b0, START_BYTE);
      end else if (r < 98) begin
        send_item(1'b0, BYTE_W'($urandom_range(0, 255)));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    int lo;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_LOWER;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_frame(0);
    send_item(1'b0, START_BYTE);
    send_item(1'b0, 8'h2F);
    send_item(1'b0, 8'h39);
    send_item(1'b0, CHAR_EIGHT);
    // start byte inside a frame is just another digit
    repeat (4) send_item(1'b0, START_BYTE);
    send_frame(75);
    send_item(1'b0, 8'hAA);
    send_tick();

    run_phase(40, 80, 1'b0);
    run_phase(0, 999, 1'b1);
    run_phase(75, 75, 1'b1);
    run_phase(0, 0, 1'b1);
    run_phase(999, 999, 1'b1);
    run_phase(600, 200, 1'b1);
    run_phase(50, 79, 1'b1);
    lo = $urandom_range(0, 999);
    run_phase(lo, $urandom_range(lo, 999), 1'b1);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* range_frame_to_haptic_pulse.f */
sv/rfhp_pkg.sv
sv/rfhp_if.sv
sv/rfhp_front.sv
sv/rfhp_queue.sv
sv/rfhp_back.sv
sv/range_frame_to_haptic_pulse.sv
sv/rfhp_checker.sv
sim/rfhp_checker.sv
sim/testbench.sv
